### rtl/tte_pkg.sv
package tte_pkg;

  localparam int BLOCK_BYTES = 512;

  localparam int OP_W    = 16;
  localparam int BLK_W   = 16;
  localparam int LEN_W   = 10;
  localparam int FLEN_W  = 32;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = 16;
  localparam int MODE_W  = 2;

  localparam logic [LEN_W-1:0]  BLOCK_LEN   = LEN_W'(BLOCK_BYTES);
  localparam logic [FLEN_W-1:0] BLOCK_LEN32 = FLEN_W'(BLOCK_BYTES);

  localparam logic [OP_W-1:0] OP_RRQ  = 16'd1;
  localparam logic [OP_W-1:0] OP_WRQ  = 16'd2;
  localparam logic [OP_W-1:0] OP_DATA = 16'd3;
  localparam logic [OP_W-1:0] OP_ACK  = 16'd4;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

  localparam int CLS_W = 3;
  localparam logic [CLS_W-1:0] CLS_OTHER = 3'd0;
  localparam logic [CLS_W-1:0] CLS_RRQ   = 3'd1;
  localparam logic [CLS_W-1:0] CLS_WRQ   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_DATA  = 3'd3;
  localparam logic [CLS_W-1:0] CLS_ACK   = 3'd4;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [BLK_W-1:0]  block;
    logic              short_data;
    logic [FLEN_W-1:0] flen;
    logic              opened;
  } tte_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] send_kind;
    logic [BLK_W-1:0]  send_block;
    logic [LEN_W-1:0]  send_length;
    logic [FLEN_W-1:0] file_offset;
    logic              store_payload;
    logic              transfer_done;
    logic [CNT_W-1:0]  ack_mismatch_count;
  } tte_res_t;

endpackage

### rtl/tte_front.sv
module tte_front import tte_pkg::*; (
  input  logic [OP_W-1:0]   opcode,
  input  logic [BLK_W-1:0]  block_number,
  input  logic [LEN_W-1:0]  payload_length,
  input  logic [FLEN_W-1:0] file_length,
  input  logic              file_opened,
  output tte_cmd_t          cmd
);

  always_comb begin
    case (opcode)
      OP_RRQ:  cmd.cls = CLS_RRQ;
      OP_WRQ:  cmd.cls = CLS_WRQ;
      OP_DATA: cmd.cls = CLS_DATA;
      OP_ACK:  cmd.cls = CLS_ACK;
      default: cmd.cls = CLS_OTHER;
    endcase
    cmd.block      = block_number;
    cmd.short_data = payload_length < BLOCK_LEN;
    cmd.flen       = file_length;
    cmd.opened     = file_opened;
  end

endmodule

### rtl/tte_queue.sv
module tte_queue import tte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tte_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output tte_cmd_t head_cmd
);

  tte_cmd_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]    count_r, count_nxt;

  assign full       = count_r == QCNT_W'(QDEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/tte_back.sv
module tte_back import tte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  tte_cmd_t head_cmd,
  output logic     pop,
  output logic     res_valid,
  input  logic     res_ready,
  output tte_res_t res
);

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [BLK_W-1:0]  cur_blk_r, cur_blk_nxt;
  logic [FLEN_W-1:0] left_r, left_nxt;
  logic [FLEN_W-1:0] offset_r, offset_nxt;
  logic [LEN_W-1:0]  last_len_r, last_len_nxt;
  logic [CNT_W-1:0]  miss_r, miss_nxt;
  logic              res_valid_r;
  tte_res_t          res_r, res_nxt;

  logic              is_read;
  logic              is_write;
  logic [FLEN_W-1:0] src_left;
  logic [FLEN_W-1:0] src_off;
  logic [LEN_W-1:0]  cut_len;
  logic [BLK_W-1:0]  blk_inc;

  assign pop       = head_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign is_read  = mode_r == MODE_READ;
  assign is_write = mode_r == MODE_WRITE;
  assign blk_inc  = cur_blk_r + 1'b1;
  assign src_left = is_read ? left_r : head_cmd.flen;
  assign src_off  = is_read ? offset_r : '0;
  assign cut_len  = (src_left < BLOCK_LEN32) ? src_left[LEN_W-1:0] : BLOCK_LEN;

  always_comb begin
    mode_nxt     = mode_r;
    cur_blk_nxt  = cur_blk_r;
    left_nxt     = left_r;
    offset_nxt   = offset_r;
    last_len_nxt = last_len_r;
    miss_nxt     = miss_r;
    res_nxt      = '0;
    if (is_read) begin
      if (head_cmd.cls == CLS_ACK) begin
        if (head_cmd.block == cur_blk_r) begin
          if (last_len_r < BLOCK_LEN) begin
            res_nxt.transfer_done = 1'b1;
            mode_nxt              = MODE_IDLE;
          end else begin
            cur_blk_nxt          = blk_inc;
            res_nxt.send_kind    = KIND_DATA;
            res_nxt.send_block   = blk_inc;
            res_nxt.send_length  = cut_len;
            res_nxt.file_offset  = src_off;
            left_nxt             = src_left - FLEN_W'(cut_len);
            offset_nxt           = src_off + FLEN_W'(cut_len);
            last_len_nxt         = cut_len;
          end
        end else begin
          res_nxt.send_kind   = KIND_DATA;
          res_nxt.send_block  = cur_blk_r;
          res_nxt.send_length = last_len_r;
          res_nxt.file_offset = offset_r - FLEN_W'(last_len_r);
          if (miss_r != '1) begin
            miss_nxt = miss_r + 1'b1;
          end
        end
      end
    end else if (is_write) begin
      if (head_cmd.cls == CLS_DATA && head_cmd.block == blk_inc) begin
        cur_blk_nxt           = head_cmd.block;
        res_nxt.send_kind     = KIND_ACK;
        res_nxt.send_block    = head_cmd.block;
        res_nxt.store_payload = 1'b1;
        if (head_cmd.short_data) begin
          res_nxt.transfer_done = 1'b1;
          mode_nxt              = MODE_IDLE;
        end
      end
    end else begin
      mode_nxt = MODE_IDLE;
      if (head_cmd.cls == CLS_RRQ || head_cmd.cls == CLS_WRQ) begin
        if (!head_cmd.opened) begin
          res_nxt.send_kind = KIND_ERROR;
        end else if (head_cmd.cls == CLS_RRQ) begin
          mode_nxt            = MODE_READ;
          cur_blk_nxt         = BLK_W'(1);
          miss_nxt            = '0;
          res_nxt.send_kind   = KIND_DATA;
          res_nxt.send_block  = BLK_W'(1);
          res_nxt.send_length = cut_len;
          res_nxt.file_offset = src_off;
          left_nxt            = src_left - FLEN_W'(cut_len);
          offset_nxt          = src_off + FLEN_W'(cut_len);
          last_len_nxt        = cut_len;
        end else begin
          mode_nxt          = MODE_WRITE;
          cur_blk_nxt       = '0;
          res_nxt.send_kind = KIND_ACK;
        end
      end
    end
    res_nxt.ack_mismatch_count = miss_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      cur_blk_r   <= '0;
      left_r      <= '0;
      offset_r    <= '0;
      last_len_r  <= '0;
      miss_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        mode_r     <= mode_nxt;
        cur_blk_r  <= cur_blk_nxt;
        left_r     <= left_nxt;
        offset_r   <= offset_nxt;
        last_len_r <= last_len_nxt;
        miss_r     <= miss_nxt;
      end
      if (pop) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

### rtl/tftp_transfer_engine.sv
// Server-side TFTP transfer engine. Each request is one received packet header
// and yields exactly one result, in order; send_kind of none without
// transfer_done marks an ignored packet. A front decoder classifies the opcode
// and pushes the header into a two-entry queue; the back end pops one header
// per cycle, a sustained rate of one request per cycle, while the output is not
// stalled, updates the transfer state (mode, block, remaining bytes, offset,
// last length, mismatch count) and loads the result register. A request is
// registered in a queue slot, then popped into the result register on out_.
module tftp_transfer_engine import tte_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [BLK_W-1:0]  in_block_number,
  input  logic [LEN_W-1:0]  in_payload_length,
  input  logic [FLEN_W-1:0] in_file_length,
  input  logic              in_file_opened,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_send_kind,
  output logic [BLK_W-1:0]  out_send_block,
  output logic [LEN_W-1:0]  out_send_length,
  output logic [FLEN_W-1:0] out_file_offset,
  output logic              out_store_payload,
  output logic              out_transfer_done,
  output logic [CNT_W-1:0]  out_ack_mismatch_count
);

  tte_cmd_t front_cmd;
  tte_cmd_t head_cmd;
  tte_res_t res;
  logic     q_full;
  logic     q_pop;
  logic     head_valid;

  assign in_ready = !q_full;

  tte_front u_front (
    .opcode         (in_opcode),
    .block_number   (in_block_number),
    .payload_length (in_payload_length),
    .file_length    (in_file_length),
    .file_opened    (in_file_opened),
    .cmd            (front_cmd)
  );

  tte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && in_ready),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign out_send_kind          = res.send_kind;
  assign out_send_block         = res.send_block;
  assign out_send_length        = res.send_length;
  assign out_file_offset        = res.file_offset;
  assign out_store_payload      = res.store_payload;
  assign out_transfer_done      = res.transfer_done;
  assign out_ack_mismatch_count = res.ack_mismatch_count;

endmodule

### rtl/tte_checker.sv
module tte_checker import tte_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_send_kind,
  input logic [BLK_W-1:0]  out_send_block,
  input logic [LEN_W-1:0]  out_send_length,
  input logic [FLEN_W-1:0] out_file_offset,
  input logic              out_store_payload,
  input logic              out_transfer_done,
  input logic [CNT_W-1:0]  out_ack_mismatch_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_send_kind)
      && $stable(out_send_block) && $stable(out_file_offset)
      && $stable(out_ack_mismatch_count))
    else $error("stalled result changed");

  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_kind == KIND_NONE |->
      out_send_block == '0 && out_send_length == '0 && out_file_offset == '0)
    else $error("ignored packet carries fields");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_kind == KIND_DATA |-> out_send_length <= BLOCK_LEN)
    else $error("DATA length above block size");

  a_store_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_payload |-> out_send_kind == KIND_ACK)
    else $error("store without ACK of a data block");

  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_transfer_done |->
      out_send_kind == KIND_NONE || out_send_kind == KIND_ACK)
    else $error("transfer done with DATA or ERROR");

endmodule

bind tftp_transfer_engine tte_checker u_tte_checker (.*);
